// ----- rtl/bras_pkg.sv -----
// Shared types and constants for the byte register ALU with stack.
`default_nettype none

package bras_pkg;

    // Field widths of one instruction and one result
    localparam int OPCODE_W  = 4;
    localparam int DEST_W    = 4;
    localparam int OPERAND_W = 10;
    localparam int STATUS_W  = 3;
    localparam int BYTE_W    = 8;
    localparam int SCOUNT_W  = 5;

    // Limits on immediates
    localparam logic [OPERAND_W-1:0] IMM_MAX   = 10'd255;
    localparam logic [OPERAND_W-1:0] SHIFT_MAX = 10'd7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_MOV  = 4'd0,
        OP_OR   = 4'd1,
        OP_XOR  = 4'd2,
        OP_AND  = 4'd3,
        OP_SHL  = 4'd4,
        OP_SHR  = 4'd5,
        OP_ADD  = 4'd6,
        OP_SUB  = 4'd7,
        OP_MUL  = 4'd8,
        OP_DIV  = 4'd9,
        OP_CMP  = 4'd10,
        OP_PUSH = 4'd11,
        OP_POP  = 4'd12
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_TOO_BIG = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4,
        ST_DIV0    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_EXEC,
        S_DIV,
        S_WB
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;  // capture the input transfer
        logic read_a;     // read destination register and stack top
        logic read_b;     // read source register
        logic eval;       // decode, check and compute
        logic div_step;   // one restoring division step
        logic commit;     // write back state and load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;   // instruction needs the serial divider
        logic div_last;   // final division step in progress
        logic out_free;   // result register can take a new result
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/byte_register_alu_with_stack_unit.sv -----
// Byte register ALU with stack: the sequencer below steps each instruction in turn.
// Steps: an accepted instruction passes through the register reads, execute and write-back,
//   where the result register is loaded; a register divide adds the divider steps, one bit per cycle.
// Instructions are taken one at a time; the register file has one read port and is read twice
//   per instruction, and the next one is taken after write-back, which waits for a stalled result.
// Reset: rst_n clears registers, stack count, equal flag and result valid at once.
`default_nettype none

module byte_register_alu_with_stack_unit #(
    parameter int NUM_REGS    = 8,
    parameter int STACK_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // opcode[3:0], dest_reg[7:4], operand[17:8]
    input  wire logic        s_tuser,   // operand_is_immediate
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata    // status[2:0], written_value[10:3],
                                        // equal_flag[11], stack_count[16:12]
);
    import bras_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bras_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bras_dp #(
        .NUM_REGS    (NUM_REGS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire

// ----- rtl/bras_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module bras_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/bras_ctrl.sv -----
// Instruction sequencer: steps each instruction through read, execute, divide and write-back.
`default_nettype none

module bras_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output bras_pkg::cmd_t     cmd,
    input  wire bras_pkg::sts_t sts
);
    import bras_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_RDA;
                end
            end
            S_RDA:
            begin
                cmd.read_a = 1'b1;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.read_b = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.need_div ? S_DIV : S_WB;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                // hold until the previous result has been taken
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/bras_dp.sv -----
// Datapath: register file, byte stack, equal flag, serial divider and result register.
`default_nettype none

module bras_dp #(
    parameter int NUM_REGS    = 8,
    parameter int STACK_DEPTH = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [23:0]    s_tdata,
    input  wire logic           s_tuser,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic      [23:0]    m_tdata,
    input  wire bras_pkg::cmd_t cmd,
    output bras_pkg::sts_t      sts
);
    import bras_pkg::*;

    localparam int RA_W  = NUM_REGS > 1 ? $clog2(NUM_REGS) : 1;
    localparam int SA_W  = STACK_DEPTH > 1 ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    // Latched instruction
    logic [OPCODE_W-1:0]  op_reg;
    logic [DEST_W-1:0]    dst_reg;
    logic [OPERAND_W-1:0] opnd_reg;
    logic                 imm_reg;

    // Architectural state
    logic [NUM_REGS-1:0]  rf_vld_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 eq_reg;

    // Register file access
    logic                 d_ok;
    logic                 o_ok;
    logic [RA_W-1:0]      dst_idx;
    logic [RA_W-1:0]      opnd_idx;
    logic [RA_W-1:0]      rf_raddr;
    logic                 rf_raddr_ok;
    logic                 rf_we;
    logic [BYTE_W-1:0]    rf_wdata;
    logic [BYTE_W-1:0]    rf_rdata;
    logic                 rd_vld_reg;
    logic [BYTE_W-1:0]    rf_val;
    logic [BYTE_W-1:0]    a_reg;

    // Stack access
    logic [CNT_W-1:0]     cnt_dec;
    logic [BYTE_W-1:0]    stk_rdata;
    logic                 stk_we;

    // Evaluation
    logic [BYTE_W-1:0]    b_val;
    logic [BYTE_W-1:0]    sh_val;
    logic [2*BYTE_W-1:0]  prod;
    status_t              ev_status;
    logic [BYTE_W-1:0]    ev_value;
    logic                 ev_rf_we;
    logic [RA_W-1:0]      ev_rf_addr;
    logic                 ev_rf_zero;
    logic                 ev_push;
    logic                 ev_pop;
    logic                 ev_eq_we;
    logic                 ev_eq;
    logic                 ev_div;

    // Pending actions for write-back
    status_t              act_status_reg;
    logic [BYTE_W-1:0]    act_value_reg;
    logic                 act_rf_we_reg;
    logic [RA_W-1:0]      act_rf_addr_reg;
    logic                 act_rf_zero_reg;
    logic                 act_push_reg;
    logic                 act_pop_reg;
    logic                 act_eq_we_reg;
    logic                 act_eq_reg;
    logic                 act_div_reg;

    // Serial divider
    logic [BYTE_W-1:0]    div_rem_reg;
    logic [BYTE_W-1:0]    div_quo_reg;
    logic [BYTE_W-1:0]    div_dvs_reg;
    logic [2:0]           div_cnt_reg;
    logic [BYTE_W:0]      div_trial;

    // Commit values
    logic [BYTE_W-1:0]    final_value;
    logic [CNT_W-1:0]     cnt_next;
    logic                 eq_next;

    // Result register
    logic                 out_vld_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [BYTE_W-1:0]    out_value_reg;
    logic                 out_eq_reg;
    logic [SCOUNT_W-1:0]  out_cnt_reg;

    // Instruction capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= s_tdata[3:0];
            dst_reg  <= s_tdata[7:4];
            opnd_reg <= s_tdata[17:8];
            imm_reg  <= s_tuser;
        end
    end

    assign d_ok     = {1'b0, dst_reg} < (DEST_W + 1)'(NUM_REGS);
    assign o_ok     = opnd_reg < OPERAND_W'(NUM_REGS);
    assign dst_idx  = dst_reg[RA_W-1:0];
    assign opnd_idx = opnd_reg[RA_W-1:0];

    // Register file read address: destination first, then source
    assign rf_raddr    = cmd.read_a ? dst_idx : opnd_idx;
    assign rf_raddr_ok = cmd.read_a ? d_ok : o_ok;

    bras_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (NUM_REGS)
    ) u_rf (
        .clk   (clk),
        .we    (rf_we),
        .waddr (act_rf_addr_reg),
        .wdata (rf_wdata),
        .re    (cmd.read_a | cmd.read_b),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    // Entries never written read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.read_a || cmd.read_b)
        begin
            rd_vld_reg <= rf_raddr_ok && rf_vld_reg[rf_raddr];
        end
    end

    assign rf_val = rd_vld_reg ? rf_rdata : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.read_b)
        begin
            a_reg <= rf_val;
        end
    end

    // Stack: top entry read with the destination register
    assign cnt_dec = cnt_reg - 1'b1;
    assign stk_we  = cmd.commit && act_push_reg;

    bras_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (cnt_reg[SA_W-1:0]),
        .wdata (act_value_reg),
        .re    (cmd.read_a),
        .raddr (cnt_dec[SA_W-1:0]),
        .rdata (stk_rdata)
    );

    // Operand, product and shift results
    assign b_val  = imm_reg ? opnd_reg[BYTE_W-1:0] : rf_val;
    assign prod   = a_reg * b_val;
    assign sh_val = (b_val > 8'd7) ? '0 :
                    (op_reg == OP_SHL) ? (a_reg << b_val[2:0]) : (a_reg >> b_val[2:0]);

    // Decode, checks in priority order, and the resulting action
    always_comb
    begin
        ev_status  = ST_OK;
        ev_value   = '0;
        ev_rf_we   = 1'b0;
        ev_rf_addr = dst_idx;
        ev_rf_zero = 1'b0;
        ev_push    = 1'b0;
        ev_pop     = 1'b0;
        ev_eq_we   = 1'b0;
        ev_eq      = 1'b0;
        ev_div     = 1'b0;
        case (op_reg)
            OP_MOV:
            begin
                if (!d_ok)
                    ev_status = ST_UNKNOWN;
                else if (imm_reg && opnd_reg > IMM_MAX)
                    ev_status = ST_TOO_BIG;
                else if (!imm_reg && !o_ok)
                    ev_status = ST_UNKNOWN;
                else
                begin
                    ev_rf_we = 1'b1;
                    ev_value = b_val;
                end
            end
            OP_SHL, OP_SHR:
            begin
                if (!d_ok)
                    ev_status = ST_UNKNOWN;
                else if (imm_reg && opnd_reg > SHIFT_MAX)
                    ev_status = ST_TOO_BIG;
                else if (!imm_reg && !o_ok)
                    ev_status = ST_UNKNOWN;
                else
                begin
                    ev_rf_we = 1'b1;
                    ev_value = sh_val;
                end
            end
            OP_OR, OP_XOR, OP_AND, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP:
            begin
                if (!d_ok || imm_reg || !o_ok)
                    ev_status = ST_UNKNOWN;
                else
                begin
                    ev_rf_we = 1'b1;
                    case (op_reg)
                        OP_OR:  ev_value = a_reg | b_val;
                        OP_XOR: ev_value = a_reg ^ b_val;
                        OP_AND: ev_value = a_reg & b_val;
                        OP_ADD: ev_value = a_reg + b_val;
                        OP_SUB: ev_value = a_reg - b_val;
                        OP_MUL: ev_value = prod[BYTE_W-1:0];
                        OP_DIV:
                        begin
                            if (b_val == '0)
                            begin
                                ev_status = ST_DIV0;
                                ev_rf_we  = 1'b0;
                            end
                            else
                            begin
                                ev_div = 1'b1;
                            end
                        end
                        default:
                        begin
                            // compare only updates the flag
                            ev_rf_we = 1'b0;
                            ev_eq_we = 1'b1;
                            ev_eq    = (a_reg == b_val);
                        end
                    endcase
                end
            end
            OP_PUSH:
            begin
                if (imm_reg && opnd_reg > IMM_MAX)
                    ev_status = ST_TOO_BIG;
                else if (!imm_reg && !o_ok)
                    ev_status = ST_UNKNOWN;
                else if (cnt_reg >= CNT_W'(STACK_DEPTH))
                    ev_status = ST_FULL;
                else
                begin
                    // a pushed register is cleared
                    ev_push    = 1'b1;
                    ev_value   = b_val;
                    ev_rf_we   = !imm_reg;
                    ev_rf_zero = 1'b1;
                    ev_rf_addr = opnd_idx;
                end
            end
            OP_POP:
            begin
                if (cnt_reg == '0)
                    ev_status = ST_EMPTY;
                else if (!d_ok)
                    ev_status = ST_UNKNOWN;
                else
                begin
                    ev_pop   = 1'b1;
                    ev_rf_we = 1'b1;
                    ev_value = stk_rdata;
                end
            end
            default:
            begin
                ev_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            act_status_reg  <= ev_status;
            act_value_reg   <= ev_value;
            act_rf_we_reg   <= ev_rf_we;
            act_rf_addr_reg <= ev_rf_addr;
            act_rf_zero_reg <= ev_rf_zero;
            act_push_reg    <= ev_push;
            act_pop_reg     <= ev_pop;
            act_eq_we_reg   <= ev_eq_we;
            act_eq_reg      <= ev_eq;
            act_div_reg     <= ev_div;
        end
    end

    // Restoring divider, one quotient bit per cycle
    assign div_trial = {div_rem_reg, div_quo_reg[BYTE_W-1]} - {1'b0, div_dvs_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= a_reg;
            div_dvs_reg <= b_val;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (!div_trial[BYTE_W])
            begin
                div_rem_reg <= div_trial[BYTE_W-1:0];
                div_quo_reg <= {div_quo_reg[BYTE_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= {div_rem_reg[BYTE_W-2:0], div_quo_reg[BYTE_W-1]};
                div_quo_reg <= {div_quo_reg[BYTE_W-2:0], 1'b0};
            end
        end
    end

    // Write-back values
    assign final_value = act_div_reg ? div_quo_reg : act_value_reg;
    assign rf_we       = cmd.commit && act_rf_we_reg;
    assign rf_wdata    = act_rf_zero_reg ? '0 : final_value;
    assign cnt_next    = act_push_reg ? cnt_reg + 1'b1 :
                         act_pop_reg  ? cnt_dec : cnt_reg;
    assign eq_next     = act_eq_we_reg ? act_eq_reg : eq_reg;

    // Architectural state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg <= '0;
            cnt_reg    <= '0;
            eq_reg     <= 1'b0;
        end
        else if (cmd.commit)
        begin
            if (act_rf_we_reg)
            begin
                rf_vld_reg[act_rf_addr_reg] <= 1'b1;
            end
            cnt_reg <= cnt_next;
            eq_reg  <= eq_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg <= act_status_reg;
            out_value_reg  <= final_value;
            out_eq_reg     <= eq_next;
            out_cnt_reg    <= SCOUNT_W'(cnt_next);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_cnt_reg, out_eq_reg, out_value_reg, out_status_reg};

    // Status towards the controller
    assign sts.need_div = ev_div;
    assign sts.div_last = (div_cnt_reg == 3'd7);
    assign sts.out_free = !out_vld_reg || m_tready;

endmodule

`default_nettype wire

// ----- rtl/bras_chk.sv -----
// Port-level checks for the byte register ALU with stack, bound to the top level.
`default_nettype none

module bras_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] s_tdata,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);
    import bras_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Instructions are taken one at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A failed instruction reports a zero written value
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != ST_OK) |-> (m_tdata[10:3] == 8'd0))
        else $error("non-zero value reported with an error status");

    // Empty-stack error only with an empty stack
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == ST_EMPTY) |-> (m_tdata[16:12] == 5'd0))
        else $error("stack empty reported with a non-zero count");

endmodule

bind byte_register_alu_with_stack_unit bras_chk u_bras_chk (.*);

`default_nettype wire
